// ===== rtl/emrs_pkg.sv =====
// Shared types and constants for the extent map read splitter
package emrs_pkg;

    localparam int FILE_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int LEN_W   = 31;
    localparam int IDX_W   = 5;
    localparam int ALIGN_W = 5;
    localparam int COUNT_W = 6;

    typedef enum logic [2:0] {
        ST_PIECE       = 3'd0,
        ST_LOADED      = 3'd1,
        ST_WRONG_STATE = 3'd2,
        ST_BEYOND_END  = 3'd3,
        ST_NO_PART     = 3'd4,
        ST_BAD_ALIGN   = 3'd5,
        ST_RAN_PAST    = 3'd6
    } t_status;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_FILE_SIZE  = 2'd0,
        CFG_ALIGN_LOG2 = 2'd1,
        CFG_PART_COUNT = 2'd2,
        CFG_FLUSHING   = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_CLIP,
        S_ALIGN,
        S_CACHE,
        S_PROBE,
        S_TEST,
        S_SETUP,
        S_PIECE,
        S_REPLY
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic [IDX_W-1:0]    entry_index;
        logic [FILE_W-1:0]   entry_logical_start;
        logic [SIZE_W-1:0]   entry_size;
        logic [FILE_W-1:0]   entry_physical_start;
        logic [FILE_W-1:0]   position;
        logic [LEN_W-1:0]    length;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    part_index;
        logic [FILE_W-1:0]   physical_offset;
        logic [LEN_W-1:0]    piece_length;
        logic                last;
    } t_out_item;

    typedef struct packed {
        t_cfg_reg            index;
        logic [FILE_W-1:0]   value;
    } t_cfg_item;

    typedef struct packed {
        logic [FILE_W-1:0]   logical_start;
        logic [SIZE_W-1:0]   size;
        logic [FILE_W-1:0]   physical_start;
    } t_entry;

    typedef struct packed {
        logic below;
        logic after;
    } t_cmp;

endpackage

// ===== rtl/emrs_chan_if.sv =====
// Valid/ready channel carrying one payload item
interface emrs_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/emrs_table.sv =====
// Extent table memory with registered read and the shared extent compare unit
module emrs_table
    import emrs_pkg::*;
#(
    parameter int MAX_PARTS = 32,
    localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [PW-1:0]     i_waddr,
    input  t_entry            i_wentry,
    input  logic              i_re,
    input  logic [PW-1:0]     i_raddr,
    input  logic [FILE_W-1:0] i_pos,
    output t_entry            o_entry,
    output t_cmp              o_cmp
);

    t_entry            r_mem [MAX_PARTS];
    t_entry            r_rd;
    logic [FILE_W:0]   end_sum;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wentry;
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    always_comb begin
        end_sum      = {1'b0, r_rd.logical_start} + (FILE_W+1)'(r_rd.size);
        o_cmp.below  = i_pos < r_rd.logical_start;
        o_cmp.after  = {1'b0, i_pos} >= end_sum;
    end

    assign o_entry = r_rd;

endmodule

// ===== rtl/extent_map_read_splitter.sv =====
// Top level: maps a logical read onto the extent table and splits it into pieces
//
// i_cfg writes one of four registers (file size, alignment, part count,
// flushing); it is ready out of reset and is to be written only while the block
// is idle; the block itself does not enforce this. i_in takes a load command,
// which fills one table slot, or a read request. o_out gives the results of each
// item; the final one carries last. A load result goes through the reply state
// into the output register. A read passes the pre, clip and align states for the
// end-of-file clip and alignment checks, the cache state for the last-hit cache,
// then a probe and a test state per binary-search probe of the extent table (up
// to six probes for 32 extents), one setup state and one piece per cycle while
// the receiver is not stalling. All probes and piece steps share one table read
// port; the cache check and all probes share one extent compare unit.
// i_in is ready only while no item is at work and reset is released.
// A stalled receiver holds the output register, and the sequencer waits on it.
// Reset clears the state, the configuration, the cache and the output valid; the
// table itself is not cleared and slots must be loaded before reads reach them.
module extent_map_read_splitter
    import emrs_pkg::*;
#(
    parameter int MAX_PARTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    emrs_chan_if.sink    i_cfg,
    emrs_chan_if.sink    i_in,
    emrs_chan_if.source  o_out
);

    localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int NW = $clog2(MAX_PARTS + 1);

    t_state              r_state, n_state;
    logic [FILE_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [FILE_W:0]     r_end, n_end;
    logic [FILE_W:0]     r_total, n_total;
    logic [NW-1:0]       r_lo, n_lo;
    logic [NW-1:0]       r_hi, n_hi;
    logic [PW-1:0]       r_part, n_part;
    logic [SIZE_W-1:0]   r_off, n_off;
    logic [PW-1:0]       r_cache_part, n_cache_part;
    logic                r_cache_valid, n_cache_valid;
    t_status             r_status, n_status;
    logic                r_o_valid, n_o_valid;
    t_out_item           r_o_item, n_o_item;
    logic [FILE_W-1:0]   r_file_size, n_file_size;
    logic [ALIGN_W-1:0]  r_align_log2, n_align_log2;
    logic [COUNT_W-1:0]  r_part_count, n_part_count;
    logic                r_flushing, n_flushing;

    logic                in_acc;
    logic                out_free;
    logic                we;
    logic                rd_en;
    logic [PW-1:0]       rd_addr;
    t_entry              wentry;
    t_entry              entry;
    t_cmp                cmp;
    logic [FILE_W:0]     amask;
    logic [NW-1:0]       n_parts;
    logic [NW:0]         mid_sum;
    logic [NW-1:0]       mid;
    logic [NW-1:0]       nxt_part;
    logic [SIZE_W-1:0]   room;
    logic                fits;
    logic [LEN_W-1:0]    take;
    logic [FILE_W-1:0]   phys;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_item;
    assign out_free    = !r_o_valid || o_out.ready;

    assign we = in_acc && (i_in.data.cmd == CMD_LOAD)
                && (32'(i_in.data.entry_index) < 32'(MAX_PARTS));
    assign wentry.logical_start  = i_in.data.entry_logical_start;
    assign wentry.size           = i_in.data.entry_size;
    assign wentry.physical_start = i_in.data.entry_physical_start;

    emrs_table #(
        .MAX_PARTS (MAX_PARTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (PW'(i_in.data.entry_index)),
        .i_wentry (wentry),
        .i_re     (rd_en),
        .i_raddr  (rd_addr),
        .i_pos    (r_pos),
        .o_entry  (entry),
        .o_cmp    (cmp)
    );

    always_comb begin
        amask    = ((FILE_W+1)'(1) << r_align_log2) - (FILE_W+1)'(1);
        n_parts  = (32'(r_part_count) > 32'(MAX_PARTS)) ? NW'(MAX_PARTS) : NW'(r_part_count);
        mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
        mid      = mid_sum[NW:1];
        nxt_part = NW'(r_part) + NW'(1);
        room     = entry.size - r_off;
        fits     = SIZE_W'(r_len) <= room;
        take     = fits ? r_len : room[LEN_W-1:0];
        phys     = entry.physical_start + FILE_W'(r_off);
    end

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_len         = r_len;
        n_end         = r_end;
        n_total       = r_total;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_part        = r_part;
        n_off         = r_off;
        n_cache_part  = r_cache_part;
        n_cache_valid = r_cache_valid;
        n_status      = r_status;
        n_o_valid     = r_o_valid;
        n_o_item      = r_o_item;
        n_file_size   = r_file_size;
        n_align_log2  = r_align_log2;
        n_part_count  = r_part_count;
        n_flushing    = r_flushing;
        rd_en         = 1'b0;
        rd_addr       = r_part;

        if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_FILE_SIZE:  n_file_size  = i_cfg.data.value;
                CFG_ALIGN_LOG2: n_align_log2 = i_cfg.data.value[ALIGN_W-1:0];
                CFG_PART_COUNT: n_part_count = i_cfg.data.value[COUNT_W-1:0];
                CFG_FLUSHING:   n_flushing   = i_cfg.data.value[0];
                default: ;
            endcase
        end

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pos = i_in.data.position;
                    n_len = i_in.data.length;
                    if (i_in.data.cmd == CMD_LOAD) begin
                        n_status = ST_LOADED;
                        n_state  = S_REPLY;
                    end else begin
                        n_state = S_PRE;
                    end
                end
            end
            S_PRE: begin
                if (r_flushing) begin
                    n_status = ST_WRONG_STATE;
                    n_state  = S_REPLY;
                end else if (r_pos > r_file_size) begin
                    n_status = ST_BEYOND_END;
                    n_state  = S_REPLY;
                end else begin
                    n_end   = {1'b0, r_pos} + (FILE_W+1)'(r_len);
                    n_total = ({1'b0, r_file_size} + amask) & ~amask;
                    n_state = S_CLIP;
                end
            end
            S_CLIP: begin
                if (r_end > {1'b0, r_file_size} && r_end > r_total) begin
                    n_len = LEN_W'(r_total - {1'b0, r_pos});
                end
                n_state = S_ALIGN;
            end
            S_ALIGN: begin
                if ((r_pos & amask[FILE_W-1:0]) != '0 || (r_len & amask[LEN_W-1:0]) != '0) begin
                    n_status = ST_BAD_ALIGN;
                    n_state  = S_REPLY;
                end else if (r_cache_valid) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cache_part;
                    n_part  = r_cache_part;
                    n_state = S_CACHE;
                end else begin
                    n_lo    = '0;
                    n_hi    = n_parts;
                    n_state = S_PROBE;
                end
            end
            S_CACHE: begin
                if (!cmp.below && !cmp.after) begin
                    n_state = S_SETUP;
                end else begin
                    n_lo    = '0;
                    n_hi    = n_parts;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = PW'(mid);
                    n_part  = PW'(mid);
                    n_state = S_TEST;
                end else begin
                    n_cache_valid = 1'b0;
                    n_status      = ST_NO_PART;
                    n_state       = S_REPLY;
                end
            end
            S_TEST: begin
                if (cmp.below) begin
                    n_hi    = NW'(r_part);
                    n_state = S_PROBE;
                end else if (cmp.after) begin
                    n_lo    = nxt_part;
                    n_state = S_PROBE;
                end else begin
                    n_cache_part  = r_part;
                    n_cache_valid = 1'b1;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                n_off   = SIZE_W'(r_pos - entry.logical_start);
                n_state = S_PIECE;
            end
            S_PIECE: begin
                if (out_free) begin
                    n_o_valid                = 1'b1;
                    n_o_item.status          = ST_PIECE;
                    n_o_item.part_index      = IDX_W'(r_part);
                    n_o_item.physical_offset = phys;
                    n_o_item.piece_length    = take;
                    n_o_item.last            = fits;
                    n_len                    = r_len - take;
                    if (fits) begin
                        n_state = S_IDLE;
                    end else if (nxt_part >= n_parts) begin
                        n_status = ST_RAN_PAST;
                        n_state  = S_REPLY;
                    end else begin
                        n_part  = PW'(nxt_part);
                        rd_en   = 1'b1;
                        rd_addr = PW'(nxt_part);
                        n_off   = '0;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_o_valid                = 1'b1;
                    n_o_item.status          = r_status;
                    n_o_item.part_index      = '0;
                    n_o_item.physical_offset = '0;
                    n_o_item.piece_length    = '0;
                    n_o_item.last            = 1'b1;
                    n_state                  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cache_part  <= '0;
            r_cache_valid <= 1'b0;
            r_o_valid     <= 1'b0;
            r_file_size   <= '0;
            r_align_log2  <= '0;
            r_part_count  <= '0;
            r_flushing    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cache_part  <= n_cache_part;
            r_cache_valid <= n_cache_valid;
            r_o_valid     <= n_o_valid;
            r_file_size   <= n_file_size;
            r_align_log2  <= n_align_log2;
            r_part_count  <= n_part_count;
            r_flushing    <= n_flushing;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_len    <= n_len;
        r_end    <= n_end;
        r_total  <= n_total;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_part   <= n_part;
        r_off    <= n_off;
        r_status <= n_status;
        r_o_item <= n_o_item;
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the extent map read splitter: table loads, read splitting, errors
module tb_top
    import emrs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    emrs_chan_if #(.t_payload(t_cfg_item)) cfg_ch ();
    emrs_chan_if #(.t_payload(t_in_item))  in_ch ();
    emrs_chan_if #(.t_payload(t_out_item)) out_ch ();

    extent_map_read_splitter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // shadow registers and extent table
    logic [47:0] cfg_file_size = '0;
    logic [4:0]  cfg_align = '0;
    logic [5:0]  cfg_parts = '0;
    logic        cfg_flush = 1'b0;
    logic [47:0] tbl_lstart [32];
    logic [31:0] tbl_size [32];
    logic [47:0] tbl_pstart [32];
    int          hit_part = 0;
    bit          hit_valid = 1'b0;

    t_out_item   pieces_due [$];
    t_out_item   got_item, want_item;
    int          fails = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on, stalls_on;
    int          hold_req = 0;

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic int active_parts();
        return (cfg_parts > 6'd32) ? 32 : int'(cfg_parts);
    endfunction

    function automatic void push_due(t_status st, int part, logic [63:0] phys,
                                     logic [63:0] take, bit last);
        t_out_item r;
        r.status          = st;
        r.part_index      = part[4:0];
        r.physical_offset = phys[47:0];
        r.piece_length    = take[30:0];
        r.last            = last;
        pieces_due.push_back(r);
    endfunction

    function automatic int probe(logic [63:0] p, int s);
        if (p < 64'(tbl_lstart[s]))
            return -1;
        if (p >= 64'(tbl_lstart[s]) + 64'(tbl_size[s]))
            return 1;
        return 0;
    endfunction

    function automatic int locate_extent(logic [63:0] p);
        int lo, hi, mid, c;
        lo = 0;
        hi = active_parts();
        if (hit_valid && probe(p, hit_part) == 0)
            return hit_part;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            c = probe(p, mid);
            if (c < 0) begin
                hi = mid;
            end else if (c > 0) begin
                lo = mid + 1;
            end else begin
                hit_part  = mid;
                hit_valid = 1'b1;
                return mid;
            end
        end
        hit_valid = 1'b0;
        return -1;
    endfunction

    function automatic void split_item(t_in_item it);
        logic [63:0] pos, len, amask, total, off, phys, room, take;
        int part, n;
        if (it.cmd == CMD_LOAD) begin
            tbl_lstart[it.entry_index] = it.entry_logical_start;
            tbl_size[it.entry_index]   = it.entry_size;
            tbl_pstart[it.entry_index] = it.entry_physical_start;
            push_due(ST_LOADED, 0, 0, 0, 1'b1);
            return;
        end
        pos = 64'(it.position);
        len = 64'(it.length);
        if (cfg_flush) begin
            push_due(ST_WRONG_STATE, 0, 0, 0, 1'b1);
            return;
        end
        if (pos > 64'(cfg_file_size)) begin
            push_due(ST_BEYOND_END, 0, 0, 0, 1'b1);
            return;
        end
        amask = (64'd1 << cfg_align) - 64'd1;
        if (pos + len > 64'(cfg_file_size)) begin
            total = (64'(cfg_file_size) + amask) & ~amask;
            if (pos + len > total)
                len = total - pos;
        end
        if ((pos & amask) != 0 || (len & amask) != 0) begin
            push_due(ST_BAD_ALIGN, 0, 0, 0, 1'b1);
            return;
        end
        part = locate_extent(pos);
        if (part < 0) begin
            push_due(ST_NO_PART, 0, 0, 0, 1'b1);
            return;
        end
        n    = active_parts();
        off  = (pos - 64'(tbl_lstart[part])) & 64'hFFFF_FFFF;
        phys = 64'(tbl_pstart[part]) + off;
        forever begin
            room = (64'(tbl_size[part]) - off) & 64'hFFFF_FFFF;
            take = (len < room) ? len : room;
            len -= take;
            push_due(ST_PIECE, part, phys, take, len == 0);
            if (len == 0)
                return;
            part++;
            if (part >= n) begin
                push_due(ST_RAN_PAST, 0, 0, 0, 1'b1);
                return;
            end
            off  = 0;
            phys = 64'(tbl_pstart[part]);
        end
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            got_item = out_ch.data;
            if (pieces_due.size() == 0) begin
                fails++;
                $display("%0t: unexpected item, expected none, got status %0d part %0d",
                         $time, got_item.status, got_item.part_index);
            end else begin
                want_item = pieces_due.pop_front();
                check_field("status", 64'(want_item.status), 64'(got_item.status));
                check_field("part_index", 64'(want_item.part_index),
                            64'(got_item.part_index));
                check_field("physical_offset", 64'(want_item.physical_offset),
                            64'(got_item.physical_offset));
                check_field("piece_length", 64'(want_item.piece_length),
                            64'(got_item.piece_length));
                check_field("last", 64'(want_item.last), 64'(got_item.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int pause;
        out_ch.ready = 1'b0;
        forever begin
            if (hold_req > 0) begin
                out_ch.ready = 1'b0;
                pause = hold_req;
                hold_req = 0;
                repeat (pause) @(negedge i_clk);
            end else if (stalls_on) begin
                pause = $urandom_range(0, 8);
                if (pause > 0) begin
                    out_ch.ready = 1'b0;
                    repeat (pause) @(negedge i_clk);
                end
            end
            out_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready) && hold_req == 0)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic settle();
        while (pieces_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [63:0] value);
        t_cfg_item c;
        settle();
        c.index = idx;
        c.value = value[47:0];
        cfg_ch.data  = c;
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        case (idx)
            CFG_FILE_SIZE:  cfg_file_size = value[47:0];
            CFG_ALIGN_LOG2: cfg_align = value[4:0];
            CFG_PART_COUNT: cfg_parts = value[5:0];
            CFG_FLUSHING:   cfg_flush = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_item(t_in_item it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data  = it;
        in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        split_item(it);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic load_slot(int idx, logic [63:0] ls, logic [63:0] sz, logic [63:0] ps);
        t_in_item it;
        it.cmd                  = CMD_LOAD;
        it.entry_index          = idx[4:0];
        it.entry_logical_start  = ls[47:0];
        it.entry_size           = sz[31:0];
        it.entry_physical_start = ps[47:0];
        it.position             = rand48();
        it.length               = 31'($urandom());
        send_item(it);
    endtask

    task automatic read_at(logic [63:0] pos, logic [63:0] len);
        t_in_item it;
        it.cmd                  = CMD_READ;
        it.entry_index          = 5'($urandom());
        it.entry_logical_start  = rand48();
        it.entry_size           = $urandom();
        it.entry_physical_start = rand48();
        it.position             = pos[47:0];
        it.length               = len[30:0];
        send_item(it);
    endtask

    // contiguous ascending extents, sizes a multiple of the unit
    task automatic build_table(int unit_log2, int unsigned unit_cap, logic [63:0] base,
                               bit allow_empty);
        logic [63:0] at, sz;
        at = base;
        for (int s = 0; s < 32; s++) begin
            if (allow_empty && $urandom_range(0, 15) == 0)
                sz = 0;
            else
                sz = 64'(32'($urandom_range(1, unit_cap)) << unit_log2);
            load_slot(s, at, sz, 64'(rand48()));
            at += sz;
        end
    endtask

    task automatic test_directed();
        logic [63:0] file_end;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        write_reg(CFG_ALIGN_LOG2, 0);
        write_reg(CFG_PART_COUNT, 32);
        write_reg(CFG_FLUSHING, 0);
        build_table(4, 64, 0, 1'b0);
        file_end = 64'(tbl_lstart[31]) + 64'(tbl_size[31]);
        read_at(0, 100);
        read_at(16, 0);
        write_reg(CFG_FILE_SIZE, file_end);
        read_at(0, 0);
        read_at(0, file_end);
        read_at(64'(tbl_lstart[5]) + 3, 40);
        read_at(file_end, 0);
        read_at(file_end + 1, 5);
        read_at(64'hFFFF_FFFF_FFFF, 64'h7FFF_FFFF);
        read_at(64'(tbl_lstart[30]), 100000);
        write_reg(CFG_PART_COUNT, 0);
        read_at(0, 16);
        write_reg(CFG_PART_COUNT, 63);
        read_at(64'(tbl_lstart[31]), 64'h7FFF_FFFF);
        write_reg(CFG_PART_COUNT, 32);
        read_at(64'(tbl_lstart[20]), 8);
        write_reg(CFG_PART_COUNT, 4);
        read_at(64'(tbl_lstart[20]), 64'(tbl_size[20]) + 16);
        write_reg(CFG_PART_COUNT, 8);
        read_at(64'(tbl_lstart[6]), file_end);
        write_reg(CFG_PART_COUNT, 32);
        write_reg(CFG_FILE_SIZE, file_end - 5);
        write_reg(CFG_ALIGN_LOG2, 4);
        read_at(64'(tbl_lstart[31]), 64'd1 << 20);
        read_at(64'(tbl_lstart[3]) + 1, 16);
        read_at(64'(tbl_lstart[3]), 17);
        write_reg(CFG_ALIGN_LOG2, 31);
        read_at(0, 0);
        read_at(0, 16);
        write_reg(CFG_FLUSHING, 1);
        read_at(0, 0);
        load_slot(0, 64'(tbl_lstart[0]), 64'(tbl_size[0]), 64'(tbl_pstart[0]));
        write_reg(CFG_FLUSHING, 0);
        write_reg(CFG_ALIGN_LOG2, 0);
        load_slot(10, 64'hFFFF_FFFF_0000, 64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF);
        read_at(64'(tbl_lstart[12]), 64);
        read_at(64'(tbl_lstart[9]), 64);
    endtask

    task automatic test_random_traffic(int rounds);
        int align, n, i, k, kind;
        int unsigned unit_cap;
        logic [63:0] amask, base, file_end, fsize, pos, len, span;
        for (int r = 0; r < rounds; r++) begin
            gaps_on   = r[0];
            stalls_on = r[1];
            case (r)
                1: align = 0;
                2: align = 16;
                default: align = $urandom_range(0, 12);
            endcase
            amask = (64'd1 << align) - 1;
            case ($urandom_range(0, 3))
                0: unit_cap = 4;
                1: unit_cap = 200;
                2: unit_cap = 5000;
                default: unit_cap = 32'hFFFF_FFFF >> align;
            endcase
            case ($urandom_range(0, 2))
                0: base = 0;
                1: base = 64'({2'b10, 46'(rand48())});
                default: base = 64'(rand48() >> 2);
            endcase
            base &= ~amask;
            write_reg(CFG_ALIGN_LOG2, 64'(align));
            build_table(align, unit_cap, base, 1'b1);
            file_end = 64'(tbl_lstart[31]) + 64'(tbl_size[31]);
            case ($urandom_range(0, 9))
                0, 1, 2: fsize = (file_end > amask) ?
                                 file_end - 64'($urandom_range(0, amask)) : file_end;
                3: fsize = 64'(rand48());
                default: fsize = file_end;
            endcase
            if (r == 1)
                fsize = 64'hFFFF_FFFF_FFFF;
            write_reg(CFG_FILE_SIZE, fsize);
            case ($urandom_range(0, 9))
                0, 1: write_reg(CFG_PART_COUNT, 64'($urandom_range(1, 32)));
                2: write_reg(CFG_PART_COUNT, 64'($urandom_range(33, 63)));
                default: write_reg(CFG_PART_COUNT, 32);
            endcase
            write_reg(CFG_FLUSHING, 64'($urandom_range(0, 9) == 0));
            n = active_parts();
            if (n == 0)
                n = 32;
            for (int j = 0; j < 45; j++) begin
                kind = $urandom_range(0, 99);
                i    = $urandom_range(0, n - 1);
                pos  = 64'(tbl_lstart[i]);
                if (tbl_size[i] != 0)
                    pos += 64'($urandom_range(0, tbl_size[i] - 1)) & ~amask;
                k = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(0, 3);
                span = 0;
                for (int m = i; m <= i + k && m < 32; m++)
                    span += 64'(tbl_size[m]);
                span -= pos - 64'(tbl_lstart[i]);
                if (span > 64'h7FFF_FFFF)
                    span = 64'h7FFF_FFFF;
                len = $urandom_range(0, 1) ? span : 64'($urandom_range(0, span[31:0]));
                len &= ~amask;
                if (kind < 65) begin
                    read_at(pos, len);
                end else if (kind < 73) begin
                    if ($urandom_range(0, 1))
                        read_at(pos + 1, len);
                    else
                        read_at(pos, len + 1);
                end else if (kind < 83) begin
                    if ($urandom_range(0, 1))
                        read_at(64'(rand48()), 64'($urandom()));
                    else
                        read_at(64'(rand48()) % (64'(cfg_file_size) + 1), 64'($urandom()));
                end else if (kind < 93) begin
                    pos = 64'(cfg_file_size) - 64'(cfg_file_size != 0)
                          + 64'($urandom_range(0, 2));
                    read_at(pos, $urandom_range(0, 1) ? 64'($urandom()) : len);
                end else if (kind < 97) begin
                    load_slot(i, 64'(tbl_lstart[i]), 64'(tbl_size[i]), 64'(rand48()));
                end else begin
                    load_slot($urandom_range(0, 31), 64'(rand48()), 64'($urandom()),
                              64'(rand48()));
                end
            end
        end
    endtask

    task automatic test_backpressure();
        logic [63:0] file_end;
        int i;
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        write_reg(CFG_ALIGN_LOG2, 0);
        write_reg(CFG_PART_COUNT, 32);
        write_reg(CFG_FLUSHING, 0);
        build_table(0, 8, 0, 1'b0);
        file_end = 64'(tbl_lstart[31]) + 64'(tbl_size[31]);
        write_reg(CFG_FILE_SIZE, file_end);
        hold_req = 400;
        repeat (20) begin
            i = $urandom_range(0, 20);
            read_at(64'(tbl_lstart[i]), 64'($urandom_range(1, 80)));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        gaps_on      = 1'b0;
        stalls_on    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_traffic(6);
        test_backpressure();
        settle();
        repeat (20) @(posedge i_clk);
        if (pieces_due.size() != 0) begin
            fails++;
            $display("%0t: %0d results never arrived, expected 0 left, got %0d left",
                     $time, pieces_due.size(), pieces_due.size());
        end
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
